FILE: rtl/bqn_pkg.sv
// Shared types, widths and constants of the biquad notch filter.
package bqn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 20;
  localparam int DELAY_W  = 24;
  localparam int PROD_W   = DELAY_W + COEF_W;
  localparam int ACC_W    = 48;
  localparam int IDX_W    = 3;
  localparam int SUM_W    = COEF_W + 2;
  localparam int DEN_W    = COEF_W + 1;
  localparam int NUM_W    = SAMPLE_W + 20;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 20'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 20'sd0;

  // Controls of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic mul;
    logic add;
    logic sub;
  } mac_op_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PRE  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_DFIN = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_ADD  = 9'b000100000,
    S_WRND = 9'b001000000,
    S_YRND = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

FILE: rtl/biquad_notch_filter.sv
// Top level of the biquad notch filter: registers, sequencer and output stage.
//
// Usage: one input word (sample_in, func) is taken on the in channel when
// in_valid and in_ready are both high; one result word (sample_out, clipped)
// leaves on the out channel for each input. Coefficients are written on the
// cfg channel (cfg_index 0..4 for b0, b1, b2, a1, a2; cfg_ready is always
// high); writes to other indexes are dropped. The user must write them only
// while no sample is in flight; the block itself does not enforce this.
// One sample is processed at a time: in_ready is high only while idle.
// A filter step (func 0) runs five products through one shared 24x20
// multiplier, rounding w after the first two and y after the last three,
// then hands the result to the output register. With func 1 the delay
// preset first runs the serial divider, one quotient bit per cycle over 36
// bits; the divider is skipped when b0+b1+b2 is zero.
// The result sits in an output register; the next sample may be accepted
// while it waits, but a finished result is held in the sequencer until the
// output register is free, so a stalled receiver stops the block after one
// more sample. Reset clears the delay line, loads b0 = 1.0 and zeroes the
// other coefficients, and empties the output register.
module biquad_notch_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [bqn_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic                                 func,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bqn_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                 clipped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bqn_pkg::IDX_W-1:0]            cfg_index,
  input  logic [bqn_pkg::COEF_W-1:0]           cfg_data
);

  localparam int DW = bqn_pkg::DELAY_W;
  localparam int AW = bqn_pkg::ACC_W;
  localparam logic signed [AW-1:0] D_MAX = AW'(2 ** (DW - 1) - 1);
  localparam logic signed [AW-1:0] D_MIN = -AW'(2 ** (DW - 1));
  localparam logic signed [AW-1:0] Y_MAX = AW'(2 ** (bqn_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [AW-1:0] Y_MIN = -AW'(2 ** (bqn_pkg::SAMPLE_W - 1));

  bqn_pkg::state_t state;

  logic signed [bqn_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [DW-1:0] delay_one, delay_two, w_val;
  logic signed [bqn_pkg::SAMPLE_W-1:0] x_val, y_val;
  logic [2:0] step;
  logic clip;
  logic quot_neg;
  logic out_load;

  // Preset divider operands.
  logic signed [bqn_pkg::SUM_W-1:0] csum;
  logic [bqn_pkg::SUM_W-1:0]        cabs;
  logic [bqn_pkg::SAMPLE_W-1:0]     xabs;
  logic [bqn_pkg::NUM_W-1:0]        div_num;
  logic                             div_start;
  logic                             div_done;
  logic [bqn_pkg::NUM_W-1:0]        quot;

  // Multiply-accumulate unit.
  bqn_pkg::mac_op_t mac_op;
  logic signed [AW-1:0]             mac_init;
  logic signed [DW-1:0]             mac_a;
  logic signed [bqn_pkg::COEF_W-1:0] mac_b;
  logic signed [AW-1:0]             acc;
  logic signed [AW-1:0]             w_full, y_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == bqn_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= bqn_pkg::COEF_ONE;
      coef_b1 <= bqn_pkg::COEF_ZERO;
      coef_b2 <= bqn_pkg::COEF_ZERO;
      coef_a1 <= bqn_pkg::COEF_ZERO;
      coef_a2 <= bqn_pkg::COEF_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bqn_pkg::REG_B0: coef_b0 <= cfg_data;
        bqn_pkg::REG_B1: coef_b1 <= cfg_data;
        bqn_pkg::REG_B2: coef_b2 <= cfg_data;
        bqn_pkg::REG_A1: coef_a1 <= cfg_data;
        bqn_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign csum = {{2{coef_b0[bqn_pkg::COEF_W-1]}}, coef_b0}
              + {{2{coef_b1[bqn_pkg::COEF_W-1]}}, coef_b1}
              + {{2{coef_b2[bqn_pkg::COEF_W-1]}}, coef_b2};
  assign cabs = csum[bqn_pkg::SUM_W-1] ? bqn_pkg::SUM_W'(-csum) : bqn_pkg::SUM_W'(csum);
  assign xabs = x_val[bqn_pkg::SAMPLE_W-1] ? bqn_pkg::SAMPLE_W'(-x_val)
                                            : bqn_pkg::SAMPLE_W'(x_val);
  // Adding half the divisor rounds the truncating division to nearest.
  assign div_num = {xabs, 20'b0} + bqn_pkg::NUM_W'(cabs[bqn_pkg::SUM_W-1:1]);
  assign div_start = (state == bqn_pkg::S_PRE) && (csum != '0);

  bqn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cabs[bqn_pkg::DEN_W-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    unique case (step)
      3'd0:    begin mac_a = delay_one; mac_b = coef_a1; end
      3'd1:    begin mac_a = delay_two; mac_b = coef_a2; end
      3'd2:    begin mac_a = w_val;     mac_b = coef_b0; end
      3'd3:    begin mac_a = delay_one; mac_b = coef_b1; end
      default: begin mac_a = delay_two; mac_b = coef_b2; end
    endcase
  end

  // The accumulator starts from x in Q.20 for w and from zero for y.
  assign mac_init = (step == 3'd0) ? {{(AW - bqn_pkg::SAMPLE_W){x_val[bqn_pkg::SAMPLE_W-1]}},
                                       x_val} <<< 20
                                   : '0;
  assign mac_op.clr = (state == bqn_pkg::S_MUL) && (step == 3'd0 || step == 3'd2);
  assign mac_op.mul = (state == bqn_pkg::S_MUL);
  assign mac_op.add = (state == bqn_pkg::S_ADD);
  assign mac_op.sub = (step == 3'd0 || step == 3'd1);

  bqn_mac u_mac (
    .clk  (clk),
    .op   (mac_op),
    .init (mac_init),
    .opa  (mac_a),
    .opb  (mac_b),
    .acc  (acc)
  );

  assign w_full = (acc + AW'(2 ** 15)) >>> 16;
  assign y_full = (acc + AW'(2 ** 19)) >>> 20;

  assign out_load = (state == bqn_pkg::S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bqn_pkg::S_IDLE;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      unique case (state)
        bqn_pkg::S_IDLE: begin
          if (in_valid) begin
            x_val <= sample_in;
            clip  <= 1'b0;
            step  <= 3'd0;
            state <= func ? bqn_pkg::S_PRE : bqn_pkg::S_MUL;
          end
        end
        bqn_pkg::S_PRE: begin
          quot_neg <= x_val[bqn_pkg::SAMPLE_W-1] ^ csum[bqn_pkg::SUM_W-1];
          if (csum == '0) begin
            delay_one <= DW'(x_val) <<< 4;
            delay_two <= DW'(x_val) <<< 4;
            state     <= bqn_pkg::S_MUL;
          end else begin
            state <= bqn_pkg::S_DIV;
          end
        end
        bqn_pkg::S_DIV: begin
          if (div_done) begin
            state <= bqn_pkg::S_DFIN;
          end
        end
        bqn_pkg::S_DFIN: begin
          if (!quot_neg && quot[bqn_pkg::NUM_W-1:DW-1] != '0) begin
            delay_one <= DW'(D_MAX);
            delay_two <= DW'(D_MAX);
            clip      <= 1'b1;
          end else if (quot_neg && quot > bqn_pkg::NUM_W'(2 ** (DW - 1))) begin
            delay_one <= DW'(D_MIN);
            delay_two <= DW'(D_MIN);
            clip      <= 1'b1;
          end else if (quot_neg) begin
            delay_one <= DW'(0) - quot[DW-1:0];
            delay_two <= DW'(0) - quot[DW-1:0];
          end else begin
            delay_one <= quot[DW-1:0];
            delay_two <= quot[DW-1:0];
          end
          state <= bqn_pkg::S_MUL;
        end
        bqn_pkg::S_MUL: begin
          state <= bqn_pkg::S_ADD;
        end
        bqn_pkg::S_ADD: begin
          if (step == 3'd1) begin
            state <= bqn_pkg::S_WRND;
          end else if (step == 3'd4) begin
            state <= bqn_pkg::S_YRND;
          end else begin
            step  <= step + 3'd1;
            state <= bqn_pkg::S_MUL;
          end
        end
        bqn_pkg::S_WRND: begin
          if (w_full > D_MAX) begin
            w_val <= DW'(D_MAX);
            clip  <= 1'b1;
          end else if (w_full < D_MIN) begin
            w_val <= DW'(D_MIN);
            clip  <= 1'b1;
          end else begin
            w_val <= w_full[DW-1:0];
          end
          step  <= 3'd2;
          state <= bqn_pkg::S_MUL;
        end
        bqn_pkg::S_YRND: begin
          if (y_full > Y_MAX) begin
            y_val <= bqn_pkg::SAMPLE_W'(Y_MAX);
            clip  <= 1'b1;
          end else if (y_full < Y_MIN) begin
            y_val <= bqn_pkg::SAMPLE_W'(Y_MIN);
            clip  <= 1'b1;
          end else begin
            y_val <= y_full[bqn_pkg::SAMPLE_W-1:0];
          end
          delay_two <= delay_one;
          delay_one <= w_val;
          state     <= bqn_pkg::S_DONE;
        end
        bqn_pkg::S_DONE: begin
          // Hand the word to the output register once it is free.
          if (out_load) begin
            sample_out <= y_val;
            clipped    <= clip;
            state      <= bqn_pkg::S_IDLE;
          end
        end
        default: state <= bqn_pkg::S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/bqn_div.sv
// Restoring unsigned divider, one quotient bit per cycle, for the delay preset.
module bqn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bqn_pkg::NUM_W-1:0] num,
  input  logic [bqn_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [bqn_pkg::NUM_W-1:0] quot
);

  localparam int STEPS = bqn_pkg::NUM_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                      run;
  logic [CNT_W-1:0]          cnt;
  logic [bqn_pkg::DEN_W-1:0] rem;
  logic [bqn_pkg::DEN_W+1:0] diff;

  // The quotient register also shifts out the numerator, one bit per step.
  assign diff = {1'b0, rem, quot[STEPS-1]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (run) begin
      if (diff[bqn_pkg::DEN_W+1]) begin
        rem  <= {rem[bqn_pkg::DEN_W-2:0], quot[STEPS-1]};
        quot <= {quot[STEPS-2:0], 1'b0};
      end else begin
        rem  <= diff[bqn_pkg::DEN_W-1:0];
        quot <= {quot[STEPS-2:0], 1'b1};
      end
    end
  end

endmodule

FILE: rtl/bqn_mac.sv
// Shared multiplier with a registered product and a wide accumulator.
module bqn_mac (
  input  logic                              clk,
  input  bqn_pkg::mac_op_t                  op,
  input  logic signed [bqn_pkg::ACC_W-1:0]  init,
  input  logic signed [bqn_pkg::DELAY_W-1:0] opa,
  input  logic signed [bqn_pkg::COEF_W-1:0] opb,
  output logic signed [bqn_pkg::ACC_W-1:0]  acc
);

  logic signed [bqn_pkg::PROD_W-1:0] prod;
  logic signed [bqn_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(bqn_pkg::ACC_W - bqn_pkg::PROD_W){prod[bqn_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (op.mul) begin
      prod <= opa * opb;
    end
    if (op.clr) begin
      acc <= init;
    end else if (op.add) begin
      if (op.sub) begin
        acc <= acc - prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

endmodule

FILE: tb/sv/biquad_notch_filter_test.sv
// Self-checking testbench for the biquad notch filter with a fixed-point predictor.
module biquad_notch_filter_test;

  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_WORDS    = 123;
  localparam int MAX_REPORTS    = 10;

  localparam int COEF_FRAC  = 16;
  localparam int DELAY_FRAC = 4;
  localparam int PROD_FRAC  = COEF_FRAC + DELAY_FRAC;

  localparam longint DELAY_MAX  = 64'sd8388607;
  localparam longint DELAY_MIN  = -64'sd8388608;
  localparam longint SAMPLE_MAX = 64'sd32767;
  localparam longint SAMPLE_MIN = -64'sd32768;

  typedef enum int {SET_WILD, SET_CORNER, SET_NOTCH, SET_ZERO_SUM} set_kind_t;
  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_COMB, DRAIN_STALLS} drain_mode_t;

  typedef struct packed {
    logic signed [bqn_pkg::SAMPLE_W-1:0] level;
    logic                                clip;
  } filt_result_t;

  class notch_scoreboard;
    logic signed [bqn_pkg::COEF_W-1:0]  b0, b1, b2, a1, a2;
    logic signed [bqn_pkg::DELAY_W-1:0] d1, d2;
    filt_result_t                       expected_q[$];
    bit                                 step_clip;
    int                                 errors;
    int                                 checked;

    function new();
      b0 = bqn_pkg::COEF_ONE;
      b1 = bqn_pkg::COEF_ZERO;
      b2 = bqn_pkg::COEF_ZERO;
      a1 = bqn_pkg::COEF_ZERO;
      a2 = bqn_pkg::COEF_ZERO;
      d1 = '0;
      d2 = '0;
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_coef(logic [bqn_pkg::IDX_W-1:0] idx,
                             logic [bqn_pkg::COEF_W-1:0] data);
      case (idx)
        bqn_pkg::REG_B0: b0 = data;
        bqn_pkg::REG_B1: b1 = data;
        bqn_pkg::REG_B2: b2 = data;
        bqn_pkg::REG_A1: a1 = data;
        bqn_pkg::REG_A2: a2 = data;
        default: ;
      endcase
    endfunction

    function longint saturate(longint v, longint lo, longint hi);
      if (v > hi) begin
        step_clip = 1'b1;
        return hi;
      end
      if (v < lo) begin
        step_clip = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function void note_sample(logic signed [bqn_pkg::SAMPLE_W-1:0] x, logic f);
      longint       xv, k0, k1, k2, ka1, ka2, z1, z2;
      longint       sum, num, an, ad, q, dv, acc, wv, yv;
      filt_result_t r;
      xv = x;
      k0 = b0;
      k1 = b1;
      k2 = b2;
      ka1 = a1;
      ka2 = a2;
      z1 = d1;
      z2 = d2;
      step_clip = 1'b0;
      if (f) begin
        // A zero DC gain leaves nothing to divide by, so the sample itself is loaded.
        sum = k0 + k1 + k2;
        if (sum == 0) begin
          dv = xv * (longint'(1) << DELAY_FRAC);
        end else begin
          num = xv * (longint'(1) << PROD_FRAC);
          an = (num < 0) ? -num : num;
          ad = (sum < 0) ? -sum : sum;
          q = (an + ad / 2) / ad;
          dv = ((num < 0) != (sum < 0)) ? -q : q;
        end
        dv = saturate(dv, DELAY_MIN, DELAY_MAX);
        z1 = dv;
        z2 = dv;
      end
      acc = xv * (longint'(1) << PROD_FRAC) - z1 * ka1 - z2 * ka2;
      wv = saturate((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC,
                    DELAY_MIN, DELAY_MAX);
      acc = wv * k0 + z1 * k1 + z2 * k2;
      yv = saturate((acc + (longint'(1) << (PROD_FRAC - 1))) >>> PROD_FRAC,
                    SAMPLE_MIN, SAMPLE_MAX);
      d2 = z1[bqn_pkg::DELAY_W-1:0];
      d1 = wv[bqn_pkg::DELAY_W-1:0];
      r.level = yv[bqn_pkg::SAMPLE_W-1:0];
      r.clip = step_clip;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [bqn_pkg::SAMPLE_W-1:0] y, logic c);
      filt_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: output word with none outstanding: sample_out=%0d clipped=%0b",
                   y, c);
        return;
      end
      e = expected_q.pop_front();
      if (y !== e.level) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: output word %0d: sample_out expected %0d, got %0d",
                   checked, e.level, y);
      end
      if (c !== e.clip) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: output word %0d: clipped expected %0b, got %0b",
                   checked, e.clip, c);
      end
      checked++;
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [bqn_pkg::SAMPLE_W-1:0] sample_in;
  logic                                func;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [bqn_pkg::SAMPLE_W-1:0] sample_out;
  logic                                clipped;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [bqn_pkg::IDX_W-1:0]           cfg_index;
  logic [bqn_pkg::COEF_W-1:0]          cfg_data;
  logic                                hold_request = 1'b0;
  logic                                long_hold;

  notch_scoreboard sb = new();

  biquad_notch_filter uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .clipped    (clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic logic [bqn_pkg::COEF_W-1:0] corner_coef();
    case ($urandom_range(0, 3))
      0: return 20'h7ffff;
      1: return 20'h80000;
      2: return bqn_pkg::COEF_ZERO;
      default: return bqn_pkg::COEF_ONE;
    endcase
  endfunction

  // Valid is left high after a word so that the next word follows without a bubble.
  task automatic send_item(input logic signed [bqn_pkg::SAMPLE_W-1:0] x, input logic f);
    in_valid <= 1'b1;
    sample_in <= x;
    func <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, f);
  endtask

  task automatic write_word(input logic [bqn_pkg::IDX_W-1:0] idx,
                            input logic [bqn_pkg::COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_coef(idx, data);
  endtask

  task automatic load_coefs(input logic [bqn_pkg::COEF_W-1:0] c0, c1, c2, c3, c4,
                            input bit junk);
    write_word(bqn_pkg::REG_B0, c0);
    write_word(bqn_pkg::REG_B1, c1);
    write_word(bqn_pkg::REG_B2, c2);
    write_word(bqn_pkg::REG_A1, c3);
    write_word(bqn_pkg::REG_A2, c4);
    // Indexes past the last coefficient must leave every register untouched.
    if (junk) write_word(bqn_pkg::IDX_W'(bqn_pkg::REG_A2 + $urandom_range(1, 3)),
                         bqn_pkg::COEF_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_batch(input int count);
    int                                  burst_left, gap, pick;
    logic signed [bqn_pkg::SAMPLE_W-1:0] x;
    logic                                f;
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      pick = $urandom_range(0, 9);
      if (pick == 0)
        x = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      else if (pick <= 2)
        x = bqn_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      else
        x = bqn_pkg::SAMPLE_W'($urandom());
      f = ($urandom_range(0, 9) == 0);
      send_item(x, f);
    end
  endtask

  initial begin : stimulus
    int k0, k1, k2, k3, k4, lim;
    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    func = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bqn_pkg::REG_B0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients pass the sample through; the preset loads sixteen times x.
    send_item(16'sd0, 1'b0);
    send_item(16'sh7fff, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sd1, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sh7fff, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sd12345, 1'b1);
    end_phase();

    // Zero DC gain, so the preset takes the sample itself.
    load_coefs(bqn_pkg::COEF_ONE, -20'sd131072, bqn_pkg::COEF_ONE, bqn_pkg::COEF_ZERO,
               bqn_pkg::COEF_ZERO, 1'b1);
    send_item(16'sd1000, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7fff, 1'b0);
    send_item(-16'sd5, 1'b0);
    end_phase();

    // A tiny gain drives the preset into saturation; feedback sits at its limits.
    load_coefs(20'sd1, bqn_pkg::COEF_ZERO, bqn_pkg::COEF_ZERO, 20'h7ffff, 20'h80000, 1'b0);
    send_item(16'sh7fff, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sd100, 1'b0);
    end_phase();

    load_coefs(20'h80000, 20'h7ffff, 20'h80000, 20'h80000, 20'h7ffff, 1'b1);
    send_item(16'sh7fff, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(-16'sd1, 1'b0);
    end_phase();

    load_coefs(20'sd58982, -20'sd95000, 20'sd58982, -20'sd95000, 20'sd52429, 1'b0);
    send_item(16'sd20000, 1'b1);
    send_item(-16'sd20000, 1'b0);
    send_item(16'sh7fff, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(16'sh8000, 1'b0);
    end_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      k0 = 0; k1 = 0; k2 = 0; k3 = 0; k4 = 0;
      case (set_kind_t'(p % 4))
        SET_WILD: begin
          k0 = $urandom(); k1 = $urandom(); k2 = $urandom();
          k3 = $urandom(); k4 = $urandom();
        end
        SET_CORNER: begin
          k0 = int'(corner_coef()); k1 = int'(corner_coef()); k2 = int'(corner_coef());
          k3 = int'(corner_coef()); k4 = int'(corner_coef());
        end
        SET_NOTCH: begin
          k0 = $urandom_range(30000, 70000);
          k1 = $urandom_range(0, 4 * k0) - 2 * k0;
          k2 = k0;
        end
        SET_ZERO_SUM: begin
          k0 = $urandom_range(0, 400000) - 200000;
          k1 = $urandom_range(0, 400000) - 200000;
          k2 = -k0 - k1;
        end
      endcase
      // Keep the poles inside the unit circle so the state does not run away.
      if (set_kind_t'(p % 4) == SET_NOTCH || set_kind_t'(p % 4) == SET_ZERO_SUM) begin
        k4 = $urandom_range(0, 62000);
        lim = 65535 + k4;
        k3 = $urandom_range(0, 2 * lim) - lim;
      end
      load_coefs(k0[bqn_pkg::COEF_W-1:0], k1[bqn_pkg::COEF_W-1:0], k2[bqn_pkg::COEF_W-1:0],
                 k3[bqn_pkg::COEF_W-1:0], k4[bqn_pkg::COEF_W-1:0],
                 $urandom_range(0, 1) != 0);
      if (p == 2) hold_request <= 1'b1;
      send_random_batch(PHASE_WORDS);
      end_phase();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("biquad_notch_filter regression: pass");
    else
      $display("biquad_notch_filter regression: fail");
    $finish;
  end

  // The receiver stops for a long stretch so the block backs up into its input.
  initial begin : receiver_hold
    long_hold = 1'b0;
    wait (hold_request);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : receiver
    drain_mode_t mode;
    int          mode_left, period, tick, stall_left;
    logic        nxt;
    out_ready = 1'b0;
    mode = DRAIN_FREE;
    mode_left = 0;
    period = 2;
    tick = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(sample_out, clipped);
      if (mode_left == 0) begin
        mode = drain_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
        period = $urandom_range(2, 8);
      end
      mode_left--;
      tick++;
      case (mode)
        DRAIN_FREE: nxt = 1'b1;
        DRAIN_COIN: nxt = ($urandom_range(0, 9) < 6);
        DRAIN_COMB: nxt = (tick % period == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(5, 30);
            nxt = 1'b0;
          end else begin
            nxt = 1'b1;
          end
        end
      endcase
      if (long_hold) nxt = 1'b0;
      out_ready <= nxt;
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("biquad_notch_filter regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bqn_pkg.sv
rtl/bqn_div.sv
rtl/bqn_mac.sv
rtl/biquad_notch_filter.sv
tb/sv/biquad_notch_filter_test.sv
